// File: rtl/core/spi_pkg.sv
// package for the servo pose interpolator
// widths, frame constants, register indexes and item kind codes; no dependencies
package spi_pkg;
  localparam int MaxServosDef = 18;
  localparam int PosShiftDef = 3;
  localparam int FrameMsDef = 33;

  localparam logic [1:0] KIND_SET_CUR = 2'd0;
  localparam logic [1:0] KIND_SET_TGT = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_ID = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  localparam logic [7:0] HDR_FF = 8'hFF;
  localparam logic [7:0] HDR_BCAST = 8'hFE;
  localparam logic [7:0] SYNC_WRITE = 8'h83;
  localparam logic [7:0] GOAL_REG = 8'h1E;
  localparam logic [7:0] DATA_LEN = 8'h02;
  localparam logic [9:0] FORCE_FULL = 10'd1023;
endpackage

// File: rtl/core/servo_pose_interpolator.sv
// servo pose interpolator top level: pose memories, move sequencer, frame output
// depends on spi_pkg, spi_ram, spi_div
//
// channel | direction | handshake        | payload
// in      | sink      | valid/ready      | kind, servo_index, position, lowering, move_time, adc
// out     | source    | out_valid/ready  | packet_byte, last_byte, still_moving
// cfg     | sink      | apb write/read   | four registers at 4*i
//
// set items pass through a single write state; a start runs the serial divider once per servo
// a tick while moving reads, waits for and writes back each servo's pose, then sends seven header bytes,
// a body read and three bytes per servo, and one checksum byte
// rst resets control and config, then a sweep writes every pose memory entry to its reset pose
// output stalls hold the sequencer; one item is worked at a time
module servo_pose_interpolator
  import spi_pkg::*;
#(
  parameter int MaxServos = MaxServosDef,
  parameter int PosShift = PosShiftDef,
  parameter int FrameMs = FrameMsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [1:0] kind,
  input  logic [4:0] servo_index,
  input  logic [9:0] position,
  input  logic lowering,
  input  logic [15:0] move_time,
  input  logic [9:0] adc_ch0,
  input  logic [9:0] adc_ch1,
  input  logic [9:0] adc_ch2,
  input  logic [9:0] adc_ch3,
  input  logic [9:0] adc_ch4,
  input  logic [9:0] adc_ch5,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] packet_byte,
  output logic last_byte,
  output logic still_moving,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int PW = 10 + PosShift;
  localparam int AW = (MaxServos > 1) ? $clog2(MaxServos) : 1;
  localparam int EW = PW + 1;
  localparam logic [PW-1:0] PoseReset = PW'(512) << PosShift;
  // frame count by reciprocal multiplication
  localparam int FrameShift = 16 + $clog2(FrameMs);
  localparam logic [47:0] FrameRecip =
    48'(((64'd1 << FrameShift) + 64'(FrameMs) - 64'd1) / 64'(FrameMs));

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ST_RD = 4'd2;
  localparam logic [3:0] S_ST_DIV = 4'd3;
  localparam logic [3:0] S_ST_WR = 4'd4;
  localparam logic [3:0] S_TK_RD = 4'd5;
  localparam logic [3:0] S_TK_WAIT = 4'd6;
  localparam logic [3:0] S_TK_WR = 4'd7;
  localparam logic [3:0] S_HDR = 4'd8;
  localparam logic [3:0] S_BODY_RD = 4'd9;
  localparam logic [3:0] S_BODY = 4'd10;
  localparam logic [3:0] S_SUM = 4'd11;
  localparam logic [3:0] S_SETWR = 4'd12;

  logic [3:0] state;
  logic [4:0] servo_count;
  logic [7:0] first_servo_id;
  logic [9:0] force_threshold;
  logic [9:0] sensor_offset;
  logic moving;
  logic [MaxServos-1:0] low_flags;

  // item latch
  logic [1:0] k_kind;
  logic [AW-1:0] k_idx;
  logic k_idx_ok;
  logic [PW-1:0] k_pos;
  logic k_low;
  logic [16:0] k_frames;
  logic [9:0] k_adc [6];

  logic [AW-1:0] idx;
  logic [4:0] n_act;
  logic [2:0] hcnt;
  logic [1:0] bsel;
  logic [7:0] sum;
  logic [4:0] pending;

  logic [47:0] frames_prod;
  assign frames_prod = 48'(move_time) * FrameRecip;

  // memories: pose word holds current and target
  logic pm_we;
  logic [AW-1:0] pm_addr;
  logic [2*PW-1:0] pm_wdata, pm_rdata;
  logic sm_we;
  logic [AW-1:0] sm_addr;
  logic [PW-1:0] sm_wdata, sm_rdata;

  spi_ram #(.Width(2*PW), .Depth(MaxServos)) u_pose (
    .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
  );
  spi_ram #(.Width(PW), .Depth(MaxServos)) u_speed (
    .clk(clk), .we(sm_we), .addr(sm_addr), .wdata(sm_wdata), .rdata(sm_rdata)
  );

  logic [PW-1:0] cur, tgt;
  assign cur = pm_rdata[PW-1:0];
  assign tgt = pm_rdata[2*PW-1:PW];

  logic [PW-1:0] diff;
  logic up;
  assign up = tgt > cur;
  assign diff = up ? tgt - cur : cur - tgt;

  logic div_start, div_busy;
  logic [PW-1:0] div_quo;
  logic [PW-1:0] frames_cl;
  // frames fits PW bits unless it exceeds every possible diff: then quotient is 0
  assign frames_cl = (k_frames > 17'((1 << PW) - 1)) ? {PW{1'b1}} : PW'(k_frames);
  spi_div #(.Width(PW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(diff), .den(frames_cl),
    .busy(div_busy), .quo(div_quo)
  );

  // force path
  logic [2:0] ch;
  logic offs;
  always_comb begin
    ch = 3'd5;
    offs = 1'b1;
    case (5'(idx))
      5'd0, 5'd2, 5'd4: begin ch = 3'd0; offs = 1'b1; end
      5'd1, 5'd3, 5'd5: begin ch = 3'd1; offs = 1'b0; end
      5'd12, 5'd14, 5'd16: begin ch = 3'd2; offs = 1'b0; end
      5'd13, 5'd15, 5'd17: begin ch = 3'd3; offs = 1'b1; end
      5'd6, 5'd8, 5'd10: begin ch = 3'd4; offs = 1'b0; end
      default: begin ch = 3'd5; offs = 1'b1; end
    endcase
  end
  logic signed [11:0] force_val;
  assign force_val = $signed({2'b0, FORCE_FULL}) - $signed({2'b0, k_adc[ch]})
                     - (offs ? $signed({2'b0, sensor_offset}) : 12'sd0);
  logic stop_hit;
  assign stop_hit = low_flags[idx] && (force_val > $signed({2'b0, force_threshold}));

  logic [EW-1:0] cur_add;
  assign cur_add = {1'b0, cur} + {1'b0, sm_rdata};

  logic [7:0] len;
  assign len = 8'(4 + 3 * n_act);
  logic [7:0] cur_id;
  assign cur_id = first_servo_id + 8'(idx);
  logic [9:0] cur_raw;
  assign cur_raw = 10'(cur >> PosShift);

  logic out_go;
  assign out_go = out_valid && out_ready;
  assign ready = (state == S_IDLE);
  assign pready = 1'b1;

  // output byte register
  logic byte_load;
  assign byte_load = ((state == S_HDR) || (state == S_BODY) || (state == S_SUM))
                     && (!out_valid || out_go);

  always_comb begin
    pm_we = 1'b0;
    pm_addr = idx;
    pm_wdata = pm_rdata;
    sm_we = 1'b0;
    sm_addr = idx;
    sm_wdata = '0;
    div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        pm_we = 1'b1;
        pm_wdata = {PoseReset, PoseReset};
      end
      S_IDLE: begin
        pm_addr = AW'(servo_index);
      end
      S_SETWR: begin
        pm_addr = k_idx;
        pm_we = k_idx_ok;
        if (k_kind == KIND_SET_CUR) begin
          pm_wdata = {pm_rdata[2*PW-1:PW], k_pos};
        end else begin
          pm_wdata = {k_pos, pm_rdata[PW-1:0]};
        end
      end
      S_ST_DIV: begin
        div_start = (pending == 5'd0);
      end
      S_ST_WR: begin
        sm_we = 1'b1;
        sm_wdata = low_flags[idx] ? (div_quo + 1'b1) >> 1 : div_quo + 1'b1;
      end
      S_TK_WR: begin
        pm_we = 1'b1;
        if (cur == tgt) begin
          pm_wdata = pm_rdata;
        end else if (stop_hit) begin
          pm_wdata = {cur, cur};
        end else if (up) begin
          pm_wdata = (diff < sm_rdata) ? {tgt, tgt} : {tgt, cur_add[PW-1:0]};
        end else begin
          pm_wdata = (diff < sm_rdata) ? {tgt, tgt} : {tgt, cur - sm_rdata};
        end
      end
      default: begin
      end
    endcase
  end

  logic tick_done;
  always_comb begin
    tick_done = (cur == tgt) || stop_hit || (diff < sm_rdata);
  end

  logic any_moving;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      servo_count <= 5'd18;
      first_servo_id <= 8'd1;
      force_threshold <= 10'd100;
      sensor_offset <= 10'd30;
      moving <= 1'b0;
      low_flags <= '0;
      out_valid <= 1'b0;
      pending <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_COUNT: servo_count <= pwdata[4:0];
          REG_ID: first_servo_id <= pwdata[7:0];
          REG_THRESH: force_threshold <= pwdata[9:0];
          REG_OFFSET: sensor_offset <= pwdata[9:0];
          default: begin end
        endcase
      end
      if (byte_load) begin
        out_valid <= 1'b1;
      end else if (out_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (32'(idx) == MaxServos - 1) begin
            state <= S_IDLE;
            idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (valid) begin
            k_kind <= kind;
            k_idx <= AW'(servo_index);
            k_idx_ok <= 32'(servo_index) < MaxServos;
            k_pos <= PW'(position) << PosShift;
            k_low <= lowering;
            k_frames <= 17'(frames_prod >> FrameShift) + 17'd1;
            k_adc[0] <= adc_ch0;
            k_adc[1] <= adc_ch1;
            k_adc[2] <= adc_ch2;
            k_adc[3] <= adc_ch3;
            k_adc[4] <= adc_ch4;
            k_adc[5] <= adc_ch5;
            n_act <= (32'(servo_count) > MaxServos) ? 5'(MaxServos) : servo_count;
            idx <= '0;
            any_moving <= 1'b0;
            case (kind)
              KIND_SET_CUR, KIND_SET_TGT: state <= S_SETWR;
              KIND_START: state <= S_ST_RD;
              default: state <= moving ? S_TK_RD : S_IDLE;
            endcase
          end
        end
        S_SETWR: begin
          if (k_kind == KIND_SET_TGT && k_idx_ok) begin
            low_flags[k_idx] <= k_low;
          end
          state <= S_IDLE;
        end
        S_ST_RD: begin
          if (n_act == 5'd0) begin
            moving <= 1'b1;
            state <= S_IDLE;
          end else begin
            pending <= '0;
            state <= S_ST_DIV;
          end
        end
        S_ST_DIV: begin
          if (pending == 5'd0) begin
            pending <= 5'd1;
          end else if (!div_busy) begin
            state <= S_ST_WR;
          end
        end
        S_ST_WR: begin
          if (5'(idx) + 5'd1 >= n_act) begin
            moving <= 1'b1;
            idx <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_ST_RD;
          end
        end
        S_TK_RD: begin
          state <= (n_act == 5'd0) ? S_HDR : S_TK_WAIT;
          hcnt <= '0;
        end
        S_TK_WAIT: state <= S_TK_WR;
        S_TK_WR: begin
          if (!tick_done) begin
            any_moving <= 1'b1;
          end
          if (5'(idx) + 5'd1 >= n_act) begin
            idx <= '0;
            hcnt <= '0;
            state <= S_HDR;
          end else begin
            idx <= idx + 1'b1;
            state <= S_TK_RD;
          end
        end
        S_HDR: begin
          if (!out_valid || out_go) begin
            if (hcnt == 3'd0) begin
              moving <= any_moving;
              still_moving <= any_moving;
              sum <= HDR_BCAST + len + SYNC_WRITE + GOAL_REG + DATA_LEN;
            end
            last_byte <= 1'b0;
            case (hcnt)
              3'd0, 3'd1: packet_byte <= HDR_FF;
              3'd2: packet_byte <= HDR_BCAST;
              3'd3: packet_byte <= len;
              3'd4: packet_byte <= SYNC_WRITE;
              3'd5: packet_byte <= GOAL_REG;
              default: packet_byte <= DATA_LEN;
            endcase
            hcnt <= hcnt + 1'b1;
            if (hcnt == 3'd6) begin
              state <= (n_act == 5'd0) ? S_SUM : S_BODY_RD;
              bsel <= '0;
            end
          end
        end
        S_BODY_RD: state <= S_BODY;
        S_BODY: begin
          if (!out_valid || out_go) begin
            last_byte <= 1'b0;
            case (bsel)
              2'd0: begin packet_byte <= cur_id; sum <= sum + cur_id; end
              2'd1: begin packet_byte <= cur_raw[7:0]; sum <= sum + cur_raw[7:0]; end
              default: begin
                packet_byte <= {6'd0, cur_raw[9:8]};
                sum <= sum + {6'd0, cur_raw[9:8]};
              end
            endcase
            if (bsel == 2'd2) begin
              bsel <= '0;
              if (5'(idx) + 5'd1 >= n_act) begin
                state <= S_SUM;
              end else begin
                idx <= idx + 1'b1;
                state <= S_BODY_RD;
              end
            end else begin
              bsel <= bsel + 1'b1;
            end
          end
        end
        S_SUM: begin
          if (!out_valid || out_go) begin
            last_byte <= 1'b1;
            packet_byte <= ~sum;
            idx <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_COUNT: prdata = 32'(servo_count);
      REG_ID: prdata = 32'(first_servo_id);
      REG_THRESH: prdata = 32'(force_threshold);
      REG_OFFSET: prdata = 32'(sensor_offset);
      default: prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ready |-> state == S_IDLE) else $error("ready outside idle");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (state != S_BODY && state != S_BODY_RD))
    else $error("last byte order");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(packet_byte))
    else $error("output dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_ST_DIV) else $error("divider busy out of start");
`endif
endmodule

// File: rtl/core/spi_ram.sv
// generic single-port ram with registered read
// no dependencies
module spi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/spi_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing
module spi_div #(
  parameter int Width = 13
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [Width-1:0] num,
  input  logic [Width-1:0] den,
  output logic busy,
  output logic [Width-1:0] quo
);
  logic [Width-1:0] rem;
  logic [Width-1:0] dv;
  logic [$clog2(Width+1)-1:0] cnt;
  logic [Width:0] trial;
  assign trial = {rem, quo[Width-1]} - {1'b0, dv};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= $clog2(Width+1)'(Width);
      rem <= '0;
      quo <= num;
      dv <= den;
    end else if (busy) begin
      if (!trial[Width]) begin
        rem <= trial[Width-1:0];
        quo <= {quo[Width-2:0], 1'b1};
      end else begin
        rem <= {rem[Width-2:0], quo[Width-1]};
        quo <= {quo[Width-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// File: tb/tb_top.sv
// testbench for servo_pose_interpolator: directed table, then random pose sequences
// self-checking against an in-bench pose predictor; depends on spi_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import spi_pkg::*;

  localparam int NumServos = MaxServosDef;
  localparam int Shift = PosShiftDef;
  localparam int FrameTime = FrameMsDef;
  localparam int TimeoutCycles = 1500000;
  localparam int IdleCycles = 400;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] idx;
    logic [9:0] pos;
    logic low;
    logic [15:0] mtime;
    logic [5:0][9:0] adc;
  } pose_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic last;
    logic mov;
  } frame_byte_t;

  typedef struct {
    pose_item_t item;
    int nbytes;
  } directed_row_t;

  logic clk = 0;
  logic rst;
  logic valid, ready;
  logic [1:0] kind;
  logic [4:0] servo_index;
  logic [9:0] position;
  logic lowering;
  logic [15:0] move_time;
  logic [9:0] adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, adc_ch5;
  logic out_valid, out_ready;
  logic [7:0] packet_byte;
  logic last_byte, still_moving;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  servo_pose_interpolator DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // pose predictor state
  logic [12:0] cur_pose [NumServos];
  logic [12:0] tgt_pose [NumServos];
  logic [12:0] speed [NumServos];
  logic speed_known [NumServos];
  logic low_flag [NumServos];
  logic pose_moving;
  logic [4:0] cfg_count;
  logic [7:0] cfg_id;
  logic [9:0] cfg_thresh, cfg_offset;

  frame_byte_t frame_q[$];
  int mismatches = 0;
  int items_sent = 0, frames_seen = 0, bytes_seen = 0, cfg_phases = 0;
  int burst_left = 0;
  int cycles = 0;
  bit rx_hold_done = 0;
  int rx_hold = 0;
  int rx_mode = 0;

  function automatic int active_servos();
    return (cfg_count > NumServos) ? NumServos : int'(cfg_count);
  endfunction

  function automatic int servo_force(int i, pose_item_t it);
    int ch;
    bit offs;
    int f;
    if (i == 0 || i == 2 || i == 4) begin ch = 0; offs = 1; end
    else if (i == 1 || i == 3 || i == 5) begin ch = 1; offs = 0; end
    else if (i == 12 || i == 14 || i == 16) begin ch = 2; offs = 0; end
    else if (i == 13 || i == 15 || i == 17) begin ch = 3; offs = 1; end
    else if (i == 6 || i == 8 || i == 10) begin ch = 4; offs = 0; end
    else begin ch = 5; offs = 1; end
    f = 1023 - int'(it.adc[ch]);
    if (offs) f -= int'(cfg_offset);
    return f;
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic last);
    frame_byte_t fb;
    fb.data = b;
    fb.last = last;
    fb.mov = pose_moving;
    frame_q.push_back(fb);
  endfunction

  // updates the pose state for one transaction, queues the frame it causes
  function automatic int predict_pose(pose_item_t it);
    int n;
    int done_cnt;
    int frames;
    logic [12:0] d, s, c, t;
    logic [31:0] sum;
    logic [7:0] len, id;
    logic [9:0] p;
    n = active_servos();
    case (it.kind)
      KIND_SET_CUR: begin
        if (it.idx < NumServos) cur_pose[it.idx] = {it.pos, 3'b000};
        return 0;
      end
      KIND_SET_TGT: begin
        if (it.idx < NumServos) begin
          tgt_pose[it.idx] = {it.pos, 3'b000};
          low_flag[it.idx] = it.low;
        end
        return 0;
      end
      KIND_START: begin
        frames = int'(it.mtime) / FrameTime + 1;
        for (int i = 0; i < n; i++) begin
          d = (tgt_pose[i] > cur_pose[i]) ? tgt_pose[i] - cur_pose[i]
                                          : cur_pose[i] - tgt_pose[i];
          s = 13'(int'(d) / frames + 1);
          if (low_flag[i]) s = s >> 1;
          speed[i] = s;
          speed_known[i] = 1;
        end
        pose_moving = 1;
        return 0;
      end
      default: ;
    endcase
    if (!pose_moving) return 0;
    done_cnt = n;
    for (int i = 0; i < n; i++) begin
      c = cur_pose[i];
      t = tgt_pose[i];
      if (c == t) done_cnt--;
      else if (low_flag[i] && servo_force(i, it) > int'(cfg_thresh)) begin
        tgt_pose[i] = c;
        done_cnt--;
      end else if (t > c) begin
        if (t - c < speed[i]) begin cur_pose[i] = t; done_cnt--; end
        else cur_pose[i] = c + speed[i];
      end else begin
        if (c - t < speed[i]) begin cur_pose[i] = t; done_cnt--; end
        else cur_pose[i] = c - speed[i];
      end
    end
    if (done_cnt == 0) pose_moving = 0;
    len = 8'(4 + 3 * n);
    queue_byte(HDR_FF, 0);
    queue_byte(HDR_FF, 0);
    queue_byte(HDR_BCAST, 0);
    queue_byte(len, 0);
    queue_byte(SYNC_WRITE, 0);
    queue_byte(GOAL_REG, 0);
    queue_byte(DATA_LEN, 0);
    sum = 32'(HDR_BCAST) + len + SYNC_WRITE + GOAL_REG + DATA_LEN;
    for (int i = 0; i < n; i++) begin
      id = cfg_id + 8'(i);
      p = 10'(cur_pose[i] >> Shift);
      sum += id + p[7:0] + {6'd0, p[9:8]};
      queue_byte(id, 0);
      queue_byte(p[7:0], 0);
      queue_byte({6'd0, p[9:8]}, 0);
    end
    queue_byte(~sum[7:0], 1);
    frames_seen++;
    return 8 + 3 * n;
  endfunction

  // a tick while moving must not read a speed that no start has written
  function automatic bit speed_hazard();
    if (!pose_moving) return 0;
    for (int i = 0; i < active_servos(); i++)
      if (!speed_known[i]) return 1;
    return 0;
  endfunction

  function automatic pose_item_t make_item(logic [1:0] k, logic [4:0] ix, logic [9:0] ps,
                                           logic lw, logic [15:0] mt, logic [9:0] a);
    pose_item_t it;
    it.kind = k;
    it.idx = ix;
    it.pos = ps;
    it.low = lw;
    it.mtime = mt;
    for (int c = 0; c < 6; c++) it.adc[c] = a;
    return it;
  endfunction

  task automatic send_item(pose_item_t it, output int nbytes);
    if (burst_left == 0) begin
      valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    kind <= it.kind;
    servo_index <= it.idx;
    position <= it.pos;
    lowering <= it.low;
    move_time <= it.mtime;
    adc_ch0 <= it.adc[0];
    adc_ch1 <= it.adc[1];
    adc_ch2 <= it.adc[2];
    adc_ch3 <= it.adc[3];
    adc_ch4 <= it.adc[4];
    adc_ch5 <= it.adc[5];
    valid <= 1;
    do @(posedge clk); while (!ready);
    nbytes = predict_pose(it);
    items_sent++;
    burst_left--;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_COUNT: cfg_count = val[4:0];
      REG_ID: cfg_id = val[7:0];
      REG_THRESH: cfg_thresh = val[9:0];
      default: cfg_offset = val[9:0];
    endcase
  endtask

  // lets the block finish its last transaction before a register write
  task automatic drain();
    valid <= 0;
    burst_left = 0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic configure(int cnt, int id, int thr, int off);
    drain();
    apb_write(REG_COUNT, cnt);
    apb_write(REG_ID, id);
    apb_write(REG_THRESH, thr);
    apb_write(REG_OFFSET, off);
    cfg_phases++;
  endtask

  function automatic pose_item_t random_tick();
    pose_item_t it;
    it = make_item(KIND_TICK, 5'($urandom), 10'($urandom), 1'($urandom), 16'($urandom), 0);
    for (int c = 0; c < 6; c++)
      it.adc[c] = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(880, 1023)) : 10'($urandom);
    return it;
  endfunction

  // one move: one to eight slot writes, a start, then up to 25 ticks until the pose settles, sometimes one more
  task automatic random_move();
    pose_item_t it;
    int nb;
    int nset;
    int nticks;
    logic [15:0] mt;
    nset = $urandom_range(1, 8);
    for (int s = 0; s < nset; s++) begin
      it = make_item(1'($urandom) ? KIND_SET_TGT : KIND_SET_CUR,
                     ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17)),
                     10'($urandom), 1'($urandom), 16'($urandom), 10'($urandom));
      send_item(it, nb);
    end
    mt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    send_item(make_item(KIND_START, 5'($urandom), 10'($urandom), 1'($urandom), mt,
                        10'($urandom)), nb);
    nticks = 0;
    while (pose_moving && nticks < 25) begin
      send_item(random_tick(), nb);
      nticks++;
    end
    if ($urandom_range(0, 4) == 0) send_item(random_tick(), nb);
  endtask

  // receiver: shifting stall patterns and one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ready <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 0;
    end else if (!rx_hold_done && bytes_seen >= 300) begin
      rx_hold_done <= 1;
      rx_hold <= 600;
      out_ready <= 0;
    end else begin
      if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready <= 1;
        1: out_ready <= 1'($urandom);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    frame_byte_t exp_b;
    if (!rst && out_valid && out_ready) begin
      bytes_seen <= bytes_seen + 1;
      if (frame_q.size() == 0) begin
        $error("frame byte %02h with no transaction expected", packet_byte);
        mismatches++;
      end else begin
        exp_b = frame_q.pop_front();
        if (packet_byte !== exp_b.data) begin
          $error("packet_byte: expected %02h, got %02h", exp_b.data, packet_byte);
          mismatches++;
        end
        if (last_byte !== exp_b.last) begin
          $error("last_byte: expected %0b, got %0b", exp_b.last, last_byte);
          mismatches++;
        end
        if (still_moving !== exp_b.mov) begin
          $error("still_moving: expected %0b, got %0b", exp_b.mov, still_moving);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= TimeoutCycles) begin
      $display("servo_pose_interpolator test failed");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    int nb;
    rst <= 1;
    valid <= 0;
    kind <= 0;
    servo_index <= 0;
    position <= 0;
    lowering <= 0;
    move_time <= 0;
    adc_ch0 <= 0;
    adc_ch1 <= 0;
    adc_ch2 <= 0;
    adc_ch3 <= 0;
    adc_ch4 <= 0;
    adc_ch5 <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    for (int i = 0; i < NumServos; i++) begin
      cur_pose[i] = 13'd4096;
      tgt_pose[i] = 13'd4096;
      speed[i] = 0;
      speed_known[i] = 0;
      low_flag[i] = 0;
    end
    pose_moving = 0;
    cfg_count = 18;
    cfg_id = 1;
    cfg_thresh = 100;
    cfg_offset = 30;
    repeat (9) @(posedge clk);
    rst <= 0;

    // nbytes of -1: left to the predictor
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd0), 0});
    rows.push_back('{make_item(KIND_SET_CUR, 0, 0, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_TGT, 0, 10'd1023, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_CUR, 17, 10'd1023, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_TGT, 17, 0, 1, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_CUR, 31, 10'd1023, 1, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_TGT, 18, 10'd1023, 1, 0, 0), 0});
    rows.push_back('{make_item(KIND_START, 0, 0, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd1023), 62});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd0), 62});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd1023), -1});
    rows.push_back('{make_item(KIND_SET_TGT, 3, 10'd513, 1, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_CUR, 0, 10'd500, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_SET_TGT, 0, 10'd520, 0, 0, 0), 0});
    rows.push_back('{make_item(KIND_START, 0, 0, 0, 16'hFFFF, 0), 0});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd1023), 62});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd990), -1});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd0), 62});
    rows.push_back('{make_item(KIND_START, 5'd31, 10'd1023, 1, 16'd32, 10'd1023), 0});
    rows.push_back('{make_item(KIND_TICK, 5'd31, 10'd1023, 1, 16'hFFFF, 10'd500), -1});
    rows.push_back('{make_item(KIND_TICK, 0, 0, 0, 0, 10'd1023), -1});
    foreach (rows[r]) begin
      send_item(rows[r].item, nb);
      if (rows[r].nbytes >= 0 && nb != rows[r].nbytes) begin
        $error("frame length: expected %0d, got %0d", rows[r].nbytes, nb);
        mismatches++;
      end
    end

    configure(1, 0, 0, 0);
    repeat (3) random_move();
    configure(18, 253, 1023, 1023);
    repeat (3) random_move();
    configure(0, 7, 100, 30);
    repeat (3) random_move();
    configure(31, 200, 500, 0);
    repeat (3) random_move();
    while (items_sent < 520) begin
      if ($urandom_range(0, 3) == 0)
        configure($urandom_range(0, 31), $urandom_range(0, 253),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
      random_move();
      if (speed_hazard()) drain();
    end
    drain();

    $display("covered %0d transactions, %0d frames, %0d frame bytes over %0d register settings",
             items_sent, frames_seen, bytes_seen, cfg_phases);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("servo_pose_interpolator test passed");
    end else begin
      $display("servo_pose_interpolator test failed");
    end
    $finish;
  end

endmodule
